/* design/ppe_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and codes for the projectile pool engine.
// Used by every module of the design; depends on nothing else.

package ppe_pkg;

   localparam int POOL_SLOTS   = 24;
   localparam int PLAYER_SLOTS = 16;

   localparam int SPLIT_SLOTS  = (PLAYER_SLOTS < POOL_SLOTS) ? PLAYER_SLOTS : POOL_SLOTS;
   localparam bit ENEMY_EMPTY  = (SPLIT_SLOTS == POOL_SLOTS);

   localparam int IDX_W        = $clog2(POOL_SLOTS);
   localparam int CNT_W        = $clog2(POOL_SLOTS + 1);

   localparam int COORD_W      = 16;
   localparam int BYTE_W       = 8;
   localparam int VEL_FRAC_W   = 8;
   localparam int SLOT_W       = 5;
   localparam int LIVE_W       = 5;
   localparam int KIND_W       = 2;

   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [COORD_W-1:0] MARGIN_RESET  = 16'd16;
   localparam logic [COORD_W-1:0] LIMIT_V_RESET = 16'd256;
   localparam logic [COORD_W-1:0] LIMIT_H_RESET = 16'd288;

   localparam logic [CSR_INDEX_W-1:0] CSR_CULL_MARGIN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_V     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_H     = 2'd2;

   typedef enum logic [KIND_W-1:0] {
      KIND_SPAWN = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPAWN_SCAN,
      ST_SPAWN_OUT,
      ST_DROP_OUT,
      ST_CLEAR_OUT,
      ST_TICK_RD,
      ST_TICK_Y,
      ST_TICK_X,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } ppe_state_type;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic                      owner_side;
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] speed_x;
      logic signed [COORD_W-1:0] speed_y;
      logic [BYTE_W-1:0]         object_kind;
      logic [BYTE_W-1:0]         hit_value;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]         slot_index;
      logic                      slot_live;
      logic signed [COORD_W-1:0] pos_x_out;
      logic signed [COORD_W-1:0] pos_y_out;
      logic [BYTE_W-1:0]         kind_out;
      logic [BYTE_W-1:0]         damage_out;
      logic [LIVE_W-1:0]         live_count;
      logic                      spawn_dropped;
      logic                      last_item;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] vel_x;
      logic [COORD_W-1:0] vel_y;
      logic [BYTE_W-1:0]  kind;
      logic [BYTE_W-1:0]  damage;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] rd_addr;
   } store_cmd_type;

   typedef struct packed {
      logic [COORD_W-1:0] cull_margin;
      logic [COORD_W-1:0] limit_vertical;
      logic [COORD_W-1:0] limit_horizontal;
   } cfg_type;

endpackage

/* design/ppe_store.sv */
`timescale 1ns / 1ps
// Slot memory holding position, velocity, type and damage of every slot.
// One write port and one registered read port; uses ppe_pkg.

module ppe_store (
   input  logic                    clock,
   input  ppe_pkg::store_cmd_type  cmd,
   input  ppe_pkg::entry_type      wr_entry,
   output ppe_pkg::entry_type      rd_entry
);

   ppe_pkg::entry_type mem [ppe_pkg::POOL_SLOTS];
   ppe_pkg::entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem[cmd.rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

/* design/ppe_mover.sv */
`timescale 1ns / 1ps
// Shared axis unit: adds the whole-pixel part of a velocity to a position and
// checks the margin-shifted coordinate against its limit; uses ppe_pkg.

module ppe_mover (
   input  logic [ppe_pkg::COORD_W-1:0] pos,
   input  logic [ppe_pkg::COORD_W-1:0] vel,
   input  logic [ppe_pkg::COORD_W-1:0] margin,
   input  logic [ppe_pkg::COORD_W-1:0] limit,
   output logic [ppe_pkg::COORD_W-1:0] new_pos,
   output logic                        over
);

   logic [ppe_pkg::COORD_W-1:0] step;
   logic [ppe_pkg::COORD_W-1:0] shifted;

   always_comb begin
      step    = ppe_pkg::COORD_W'($signed(vel) >>> ppe_pkg::VEL_FRAC_W);
      new_pos = pos + step;
      shifted = new_pos + margin;
      over    = (shifted > limit);
   end

endmodule

/* design/ppe_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the pool: slot scan for spawns, two-pass tick, clear, and the
// output register. Uses ppe_pkg, ppe_store and ppe_mover.

module ppe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  ppe_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  ppe_pkg::req_type  req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ppe_pkg::rsp_type  rsp_word
);

   localparam logic [ppe_pkg::IDX_W-1:0] LAST_SLOT   = ppe_pkg::IDX_W'(ppe_pkg::POOL_SLOTS - 1);
   localparam logic [ppe_pkg::IDX_W-1:0] SPLIT_LAST  = ppe_pkg::IDX_W'(ppe_pkg::SPLIT_SLOTS - 1);
   localparam logic [ppe_pkg::IDX_W-1:0] ENEMY_FIRST = ppe_pkg::IDX_W'(ppe_pkg::SPLIT_SLOTS);

   ppe_pkg::ppe_state_type          state_ff, state_in;
   logic [ppe_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic [ppe_pkg::IDX_W-1:0]       scan_last_ff, scan_last_in;
   logic [ppe_pkg::POOL_SLOTS-1:0]  live_ff, live_in;
   logic [ppe_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [ppe_pkg::LIVE_W-1:0]      total_ff, total_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   ppe_pkg::rsp_type                rsp_ff, rsp_in;
   ppe_pkg::req_type                req_ff, req_in;
   logic [ppe_pkg::COORD_W-1:0]     new_y_ff, new_y_in;
   logic                            over_y_ff, over_y_in;

   ppe_pkg::store_cmd_type          cmd;
   ppe_pkg::entry_type              wr_entry;
   ppe_pkg::entry_type              rd_entry;

   logic [ppe_pkg::COORD_W-1:0]     mv_pos, mv_vel, mv_limit, mv_new;
   logic                            mv_over;
   logic                            out_free;
   logic                            keep;
   logic [ppe_pkg::CNT_W-1:0]       count_next;

   ppe_store u_store (
      .clock    (clock),
      .cmd      (cmd),
      .wr_entry (wr_entry),
      .rd_entry (rd_entry)
   );

   ppe_mover u_mover (
      .pos     (mv_pos),
      .vel     (mv_vel),
      .margin  (cfg.cull_margin),
      .limit   (mv_limit),
      .new_pos (mv_new),
      .over    (mv_over)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppe_pkg::ST_IDLE;
         idx_ff       <= '0;
         scan_last_ff <= '0;
         live_ff      <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         scan_last_ff <= scan_last_in;
         live_ff      <= live_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      req_ff    <= req_in;
      new_y_ff  <= new_y_in;
      over_y_ff <= over_y_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      scan_last_in = scan_last_ff;
      live_in      = live_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      req_in       = req_ff;
      new_y_in     = new_y_ff;
      over_y_in    = over_y_ff;
      rsp_in       = rsp_ff;

      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      cmd.wr_en    = 1'b0;
      cmd.wr_addr  = idx_ff;
      cmd.rd_addr  = idx_ff;
      wr_entry     = rd_entry;

      mv_pos       = rd_entry.pos_x;
      mv_vel       = rd_entry.vel_x;
      mv_limit     = cfg.limit_horizontal;
      if (state_ff == ppe_pkg::ST_TICK_Y) begin
         mv_pos   = rd_entry.pos_y;
         mv_vel   = rd_entry.vel_y;
         mv_limit = cfg.limit_vertical;
      end

      keep       = live_ff[idx_ff] && !over_y_ff && !mv_over;
      count_next = count_ff + ppe_pkg::CNT_W'(keep);

      case (state_ff)
         ppe_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in = req_word;
               case (req_word.kind)
                  ppe_pkg::KIND_SPAWN: begin
                     if (req_word.owner_side) begin
                        idx_in       = ENEMY_FIRST;
                        scan_last_in = LAST_SLOT;
                        state_in     = ppe_pkg::ENEMY_EMPTY ? ppe_pkg::ST_DROP_OUT
                                                            : ppe_pkg::ST_SPAWN_SCAN;
                     end else begin
                        idx_in       = '0;
                        scan_last_in = SPLIT_LAST;
                        state_in     = ppe_pkg::ST_SPAWN_SCAN;
                     end
                  end
                  ppe_pkg::KIND_TICK: begin
                     idx_in   = '0;
                     count_in = '0;
                     state_in = ppe_pkg::ST_TICK_RD;
                  end
                  ppe_pkg::KIND_CLEAR: begin
                     live_in  = '0;
                     state_in = ppe_pkg::ST_CLEAR_OUT;
                  end
                  default: begin
                     state_in = ppe_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         ppe_pkg::ST_SPAWN_SCAN: begin
            if (!live_ff[idx_ff]) begin
               cmd.wr_en       = 1'b1;
               wr_entry.pos_x  = req_ff.start_x;
               wr_entry.pos_y  = req_ff.start_y;
               wr_entry.vel_x  = req_ff.speed_x;
               wr_entry.vel_y  = req_ff.speed_y;
               wr_entry.kind   = req_ff.object_kind;
               wr_entry.damage = req_ff.hit_value;
               live_in[idx_ff] = 1'b1;
               state_in        = ppe_pkg::ST_SPAWN_OUT;
            end else if (idx_ff == scan_last_ff) begin
               state_in = ppe_pkg::ST_DROP_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ppe_pkg::ST_SPAWN_OUT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.slot_index    = ppe_pkg::SLOT_W'(idx_ff);
               rsp_in.slot_live     = 1'b1;
               rsp_in.pos_x_out     = req_ff.start_x;
               rsp_in.pos_y_out     = req_ff.start_y;
               rsp_in.kind_out      = req_ff.object_kind;
               rsp_in.damage_out    = req_ff.hit_value;
               rsp_in.live_count    = total_ff;
               rsp_in.spawn_dropped = 1'b0;
               rsp_in.last_item     = 1'b1;
               state_in             = ppe_pkg::ST_IDLE;
            end
         end

         ppe_pkg::ST_DROP_OUT, ppe_pkg::ST_CLEAR_OUT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in               = '0;
               rsp_in.live_count    = total_ff;
               rsp_in.spawn_dropped = (state_ff == ppe_pkg::ST_DROP_OUT);
               rsp_in.last_item     = 1'b1;
               state_in             = ppe_pkg::ST_IDLE;
            end
         end

         ppe_pkg::ST_TICK_RD: begin
            state_in = ppe_pkg::ST_TICK_Y;
         end

         ppe_pkg::ST_TICK_Y: begin
            new_y_in  = mv_new;
            over_y_in = mv_over;
            state_in  = ppe_pkg::ST_TICK_X;
         end

         ppe_pkg::ST_TICK_X: begin
            if (live_ff[idx_ff]) begin
               cmd.wr_en       = 1'b1;
               wr_entry.pos_x  = mv_new;
               wr_entry.pos_y  = new_y_ff;
               live_in[idx_ff] = keep;
            end
            count_in = count_next;
            if (idx_ff == LAST_SLOT) begin
               total_in = ppe_pkg::LIVE_W'(count_next);
               idx_in   = '0;
               state_in = ppe_pkg::ST_EMIT_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ppe_pkg::ST_TICK_RD;
            end
         end

         ppe_pkg::ST_EMIT_RD: begin
            state_in = ppe_pkg::ST_EMIT_OUT;
         end

         ppe_pkg::ST_EMIT_OUT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.slot_index    = ppe_pkg::SLOT_W'(idx_ff);
               rsp_in.slot_live     = live_ff[idx_ff];
               rsp_in.pos_x_out     = rd_entry.pos_x;
               rsp_in.pos_y_out     = rd_entry.pos_y;
               rsp_in.kind_out      = rd_entry.kind;
               rsp_in.damage_out    = rd_entry.damage;
               rsp_in.live_count    = total_ff;
               rsp_in.spawn_dropped = 1'b0;
               rsp_in.last_item     = (idx_ff == LAST_SLOT);
               if (idx_ff == LAST_SLOT) begin
                  idx_in   = '0;
                  state_in = ppe_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ppe_pkg::ST_EMIT_RD;
               end
            end
         end

         default: begin
            state_in = ppe_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ppe_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

/* design/projectile_pool_engine.sv */
`timescale 1ns / 1ps
// Spawn: the requesting side's slots are scanned for a free one, which is written before the
// result is registered; a drop result follows if none is free. Clear: a single result is registered.
// Tick: each slot is read, moved in Y, then in X and culled; then every slot is reported in order.
// A new word is taken the cycle after the last result is registered; output stalls hold results.
// Reset is synchronous: it clears live flags, the stored count and the output valid
// and restores the register defaults; slot payload memory is not cleared.

module projectile_pool_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ppe_pkg::req_type                    req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ppe_pkg::rsp_type                    rsp_word,
   input  logic                                csr_write,
   input  logic [ppe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ppe_pkg::CSR_DATA_W-1:0]      csr_data
);

   ppe_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            ppe_pkg::CSR_CULL_MARGIN: cfg_in.cull_margin      = csr_data;
            ppe_pkg::CSR_LIMIT_V:     cfg_in.limit_vertical   = csr_data;
            ppe_pkg::CSR_LIMIT_H:     cfg_in.limit_horizontal = csr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cull_margin      <= ppe_pkg::MARGIN_RESET;
         cfg_ff.limit_vertical   <= ppe_pkg::LIMIT_V_RESET;
         cfg_ff.limit_horizontal <= ppe_pkg::LIMIT_H_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

/* design/ppe_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the projectile pool engine, bound to the top level.
// Uses ppe_pkg; sees the channel ports only.

module ppe_port_props (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input ppe_pkg::req_type  req_word,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ppe_pkg::rsp_type  rsp_word
);

   // A stalled result word holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   // The engine works on one word at a time; an unused kind is dropped at once.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_word.kind == ppe_pkg::KIND_SPAWN || req_word.kind == ppe_pkg::KIND_TICK ||
       req_word.kind == ppe_pkg::KIND_CLEAR) |=> req_stall)
      else $error("input taken while busy");

   // A dropped spawn reports an empty slot and closes its item.
   a_drop_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.spawn_dropped |->
         !rsp_word.slot_live && rsp_word.last_item && (rsp_word.slot_index == '0))
      else $error("dropped spawn word malformed");

   // Only the final word of an item is taken while the input side is open.
   a_idle_only_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last_item |-> req_stall)
      else $error("input open before last result");

endmodule

bind projectile_pool_engine ppe_port_props u_ppe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
